/* design/slrb_pkg.sv */
package slrb_pkg;

  // store depth must be a power of two so that positions wrap with the 32-bit count
  localparam int BUFFER_DEPTH = 8192;
  localparam int FETCH_LIMIT  = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic [31:0] after_seq;
    logic [6:0]  max_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [31:0] next_seq;
    logic [31:0] head_seq;
    logic [5:0]  byte_count;
  } out_item_t;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic push;
    logic latch;
    logic clamp;
    logic size;
    logic read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
  } dp_sts_t;

endpackage

/* design/slrb_ram.sv */
module slrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/slrb_ctrl.sv */
module slrb_ctrl
  import slrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      req_type,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLAMP = 2'd1;
  localparam logic [1:0] S_SIZE  = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_FETCH) begin
            cmd.latch = 1'b1;
            state_nxt = S_CLAMP;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_SIZE;
      end
      S_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = sts.empty ? S_IDLE : S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_clamp_then_size: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clamp |=> cmd.size)
    else $error("clamp not followed by size step");

  a_latch_then_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> cmd.clamp)
    else $error("fetch transfer not followed by clamp step");

endmodule

/* design/slrb_dp.sv */
module slrb_dp
  import slrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_item,
  output dp_sts_t   sts,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [31:0]       write_count_r, write_count_nxt;
  logic [31:0]       head_r, head_nxt;
  logic [31:0]       after_r, after_nxt;
  logic [31:0]       oldest_r, oldest_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [6:0]        len_r, len_nxt;
  logic [5:0]        n_r, n_nxt;
  logic [5:0]        rd_cnt_r, rd_cnt_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;

  logic              strobe_r, strobe_nxt;
  logic              valid_r, valid_nxt;
  logic              last_r, last_nxt;
  logic [31:0]       next_r, next_nxt;
  logic [5:0]        cnt_r, cnt_nxt;

  logic [31:0]       lo_seq;
  logic [31:0]       span;
  logic [5:0]        lenm1;
  logic [5:0]        n_fin;
  logic [7:0]        ram_rdata;

  always_comb begin
    // start clamp: raise to oldest held byte, then lower to head
    lo_seq = (after_r < oldest_r) ? oldest_r : after_r;
    span   = head_r - start_r;
    lenm1  = 6'(len_r - 7'd1);
    n_fin  = (span > {26'd0, lenm1}) ? lenm1 : span[5:0];
  end

  assign sts.empty   = (len_r == 7'd0) || (n_fin == 6'd0);
  assign sts.rd_last = (rd_cnt_r == 6'd1);

  always_comb begin
    write_count_nxt = write_count_r;
    head_nxt        = head_r;
    after_nxt       = after_r;
    oldest_nxt      = oldest_r;
    start_nxt       = start_r;
    len_nxt         = len_r;
    n_nxt           = n_r;
    rd_cnt_nxt      = rd_cnt_r;
    rd_addr_nxt     = rd_addr_r;
    strobe_nxt      = 1'b0;
    valid_nxt       = valid_r;
    last_nxt        = last_r;
    next_nxt        = next_r;
    cnt_nxt         = cnt_r;

    if (cmd.push) begin
      write_count_nxt = write_count_r + 32'd1;
    end
    if (cmd.latch) begin
      head_nxt   = write_count_r;
      after_nxt  = in_item.after_seq;
      oldest_nxt = (write_count_r > 32'(BUFFER_DEPTH)) ?
                   write_count_r - 32'(BUFFER_DEPTH) : 32'd0;
      len_nxt    = (in_item.max_len > 7'(FETCH_LIMIT)) ? 7'(FETCH_LIMIT) : in_item.max_len;
    end
    if (cmd.clamp) begin
      start_nxt = (lo_seq > head_r) ? head_r : lo_seq;
    end
    if (cmd.size) begin
      n_nxt       = n_fin;
      rd_cnt_nxt  = n_fin;
      // the kept bytes always end at the head
      rd_addr_nxt = head_r[ADDR_W-1:0] - ADDR_W'(n_fin);
      if (sts.empty) begin
        strobe_nxt = 1'b1;
        valid_nxt  = 1'b0;
        last_nxt   = 1'b1;
        next_nxt   = (len_r == 7'd0) ? after_r : head_r;
        cnt_nxt    = 6'd0;
      end
    end
    if (cmd.read) begin
      rd_addr_nxt = rd_addr_r + ADDR_W'(1);
      rd_cnt_nxt  = rd_cnt_r - 6'd1;
      strobe_nxt  = 1'b1;
      valid_nxt   = 1'b1;
      last_nxt    = sts.rd_last;
      next_nxt    = sts.rd_last ? head_r : 32'd0;
      cnt_nxt     = sts.rd_last ? n_r : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_count_r <= 32'd0;
      strobe_r      <= 1'b0;
    end else begin
      write_count_r <= write_count_nxt;
      strobe_r      <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    after_r   <= after_nxt;
    oldest_r  <= oldest_nxt;
    start_r   <= start_nxt;
    len_r     <= len_nxt;
    n_r       <= n_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rd_addr_r <= rd_addr_nxt;
    valid_r   <= valid_nxt;
    last_r    <= last_nxt;
    next_r    <= next_nxt;
    cnt_r     <= cnt_nxt;
  end

  slrb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(write_count_r[ADDR_W-1:0]),
    .wdata(in_item.data_byte),
    .re   (cmd.read),
    .raddr(rd_addr_r),
    .rdata(ram_rdata)
  );

  assign out_strobe          = strobe_r;
  assign out_item.out_byte   = valid_r ? ram_rdata : 8'd0;
  assign out_item.byte_valid = valid_r;
  assign out_item.last       = last_r;
  assign out_item.next_seq   = next_r;
  assign out_item.head_seq   = head_r;
  assign out_item.byte_count = cnt_r;

  a_read_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.read |-> rd_cnt_r != 6'd0)
    else $error("read issued with no bytes left");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && !valid_r |-> last_r && cnt_r == 6'd0)
    else $error("empty result not marked last");

  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && valid_r && last_r |-> cnt_r != 6'd0)
    else $error("last byte result with zero count");

endmodule

/* design/sequenced_log_ring_buffer.sv */
// push: no result; the next transfer can follow in the next cycle
// fetch: busy after the transfer while the clamp and size steps set the range, then one
//   store read per cycle streams the n bytes returned (none for an empty fetch)
// an empty result is registered from the size step and each byte from its store read,
//   one result per cycle; results are strobed for one cycle and cannot stall
// synchronous reset clears the byte count and the controller; store contents stay undefined
module sequenced_log_ring_buffer
  import slrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  slrb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .req_type(in_item.req_type),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  slrb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

/* sim/sequenced_log_ring_buffer_test.sv */
module sequenced_log_ring_buffer_test
  import slrb_pkg::*;
;

  typedef struct {
    in_item_t    req;
    int unsigned gap_pct;
  } queued_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  queued_req_t pending_reqs[$];
  out_item_t   expected_results[$];

  // predictor state
  logic [7:0]  trace_mem [BUFFER_DEPTH];
  logic [31:0] trace_head = '0;

  // generator side
  logic [31:0] queued_head = '0;
  int unsigned gen_gap = 6;
  int          mismatch_count = 0;

  sequenced_log_ring_buffer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic apply_request(input in_item_t t);
    logic [31:0] head;
    logic [31:0] oldest;
    logic [31:0] first;
    logic [31:0] n;
    logic [31:0] pos;
    logic [6:0]  size;
    out_item_t   r;
    if (t.req_type == REQ_PUSH) begin
      trace_mem[trace_head[ADDR_W-1:0]] = t.data_byte;
      trace_head = trace_head + 1;
    end else begin
      head = trace_head;
      size = (t.max_len > FETCH_LIMIT) ? 7'(FETCH_LIMIT) : t.max_len;
      r = '0;
      r.last = 1'b1;
      r.head_seq = head;
      if (size == 0) begin
        r.next_seq = t.after_seq;
        expected_results.push_back(r);
      end else begin
        oldest = (head > BUFFER_DEPTH) ? head - BUFFER_DEPTH : '0;
        first = t.after_seq;
        if (first < oldest) first = oldest;
        if (first > head) first = head;
        n = head - first;
        // keep the newest bytes when the reader's buffer is too small
        if (n > 32'(size) - 1) begin
          n = 32'(size) - 1;
          first = head - n;
        end
        if (n == 0) begin
          r.next_seq = first;
          expected_results.push_back(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            pos = first + i;
            r.out_byte   = trace_mem[pos[ADDR_W-1:0]];
            r.byte_valid = 1'b1;
            r.last       = (i + 1 == n);
            r.next_seq   = r.last ? first + n : '0;
            r.byte_count = r.last ? 6'(n) : '0;
            expected_results.push_back(r);
          end
        end
      end
    end
  endtask

  // driver: a transfer happens on a rising edge with start high and busy low
  always @(posedge clk) begin : drive_proc
    logic        took;
    queued_req_t nxt;
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      took = start && !busy;
      if (took) apply_request(in_item);
      if (!start || took) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].gap_pct) begin
          nxt = pending_reqs.pop_front();
          start   <= 1'b1;
          in_item <= nxt.req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: byte=%h valid=%b last=%b next=%h head=%h count=%0d",
                   out_item.out_byte, out_item.byte_valid, out_item.last,
                   out_item.next_seq, out_item.head_seq, out_item.byte_count);
      end else begin
        want = expected_results.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.byte_valid !== want.byte_valid ||
            out_item.last !== want.last || out_item.next_seq !== want.next_seq ||
            out_item.head_seq !== want.head_seq || out_item.byte_count !== want.byte_count)
        begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch exp: byte=%h valid=%b last=%b next=%h head=%h count=%0d",
                     want.out_byte, want.byte_valid, want.last,
                     want.next_seq, want.head_seq, want.byte_count);
            $display("         got: byte=%h valid=%b last=%b next=%h head=%h count=%0d",
                     out_item.out_byte, out_item.byte_valid, out_item.last,
                     out_item.next_seq, out_item.head_seq, out_item.byte_count);
          end
        end
      end
    end
  end

  task automatic add_push(input logic [7:0] b);
    queued_req_t q;
    q.req.req_type  = REQ_PUSH;
    q.req.data_byte = b;
    q.req.after_seq = $urandom();
    q.req.max_len   = 7'($urandom_range(127));
    q.gap_pct = gen_gap;
    pending_reqs.push_back(q);
    queued_head = queued_head + 1;
  endtask

  task automatic add_fetch(input logic [31:0] after, input logic [6:0] len);
    queued_req_t q;
    q.req.req_type  = REQ_FETCH;
    q.req.data_byte = 8'($urandom());
    q.req.after_seq = after;
    q.req.max_len   = len;
    q.gap_pct = gen_gap;
    pending_reqs.push_back(q);
  endtask

  task automatic add_random_mix(input int count);
    logic [31:0] after;
    logic [6:0]  len;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 60) begin
        add_push(8'($urandom()));
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: after = queued_head - $urandom_range(70);
          5, 6:          after = $urandom();
          7, 8:          after = queued_head + $urandom_range(1, 100);
          default:       after = $urandom_range(queued_head);
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: len = 7'($urandom_range(1, 65));
          6, 7:             len = 7'($urandom_range(127));
          8:                len = 7'(FETCH_LIMIT);
          default:          len = '0;
        endcase
        add_fetch(after, len);
      end
    end
  endtask

  initial begin
    gen_gap = 6;
    add_fetch(32'h0, 7'd64);            // nothing written yet
    add_fetch(32'hFFFF_FFFF, 7'd0);     // zero size echoes the sequence
    add_fetch(32'h0, 7'd1);             // size one leaves no room for bytes
    add_push(8'h00);
    add_push(8'hFF);
    add_push(8'hA5);
    add_push(8'h5A);
    add_push(8'h01);
    add_push(8'h80);
    add_push(8'h7F);
    add_push(8'hFE);
    add_fetch(32'h0, 7'd64);
    add_fetch(32'h0, 7'd4);             // cap keeps the newest three
    add_fetch(32'hFFFF_FFFF, 7'd64);    // past the head
    add_fetch(32'd3, 7'd127);           // oversize request
    add_fetch(32'd5, 7'd65);
    add_fetch(32'h0, 7'd0);
    add_fetch(32'd8, 7'd2);             // start at head
    add_fetch(32'd7, 7'd2);
    add_fetch(32'h8000_0000, 7'd64);
    add_random_mix(120);
    gen_gap = 74;
    add_random_mix(120);
    gen_gap = 0;
    add_random_mix(120);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
